// ===== hw/rtl/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and per-octant constants for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

  // Octant number, counterclockwise from the positive x axis.
  typedef logic [2:0] octant_t;

  // Item opcodes carried on the action field.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // Per-octant flags, indexed by octant number.
  // Major axis is x.
  localparam logic [7:0] OCT_XMAJOR = 8'b1001_1001;
  // The x coordinate moves up.
  localparam logic [7:0] OCT_XINC   = 8'b1100_0011;
  // The y coordinate moves up.
  localparam logic [7:0] OCT_YINC   = 8'b0000_1111;
  // The minor step is taken when the error is above zero (else below zero).
  localparam logic [7:0] OCT_GT     = 8'b0100_1011;

endpackage : bls_pkg

// ===== hw/rtl/bresenham_line_stepper_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core
// Integer line rasterizer: a load item sets up a line, each step item moves
// one pixel along it and reports the new point.
// ----------------------------------------------------------------------------
// Results are registered: into the output register, or into the skid entry while the output is held.
// Throughput: one item per cycle while the skid entry is empty; the line state updates in the accept cycle.
// An output register plus one skid entry decouple the two channels.
// Reset clears the line state (no line loaded, point at the origin) and
// empties both result registers.
module bresenham_line_stepper_core
  import bls_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pos_x_o,
  output logic [COORD_BITS-1:0] pos_y_o,
  output logic                  on_line_o,
  output logic [2:0]            octant_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 3;

  typedef struct packed {
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic          on_line;
    octant_t       octant;
  } result_t;

  // Line state.
  logic [CW-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0]        stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  logic [CW-1:0]        mag_dx_q, mag_dx_d, mag_dy_q, mag_dy_d;
  logic signed [EW-1:0] error_q, error_d;
  octant_t              octant_q, octant_d;
  logic                 active_q, active_d;

  // Result registers.
  result_t out_q, skid_q, res_d;
  logic    out_valid_q, skid_valid_q;

  logic in_fire, out_fire;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_q & out_ready_i;

  // Load setup: signed deltas, magnitudes, octant and initial error.
  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        ax, ay;
  octant_t              ld_oct;
  logic signed [EW-1:0] ld_maj, ld_mnr, ld_err;

  always_comb begin
    dx = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    if (dx > 0 && dy >= 0) begin
      ld_oct = (ax > ay) ? octant_t'(0) : octant_t'(1);
    end else if (dx <= 0 && dy > 0) begin
      ld_oct = (ax < ay) ? octant_t'(2) : octant_t'(3);
    end else if (dx < 0 && dy <= 0) begin
      ld_oct = (ax >= ay) ? octant_t'(4) : octant_t'(5);
    end else begin
      ld_oct = (ax < ay) ? octant_t'(6) : octant_t'(7);
    end
    ld_maj = OCT_XMAJOR[ld_oct] ? $signed(EW'(ax)) : $signed(EW'(ay));
    ld_mnr = OCT_XMAJOR[ld_oct] ? $signed(EW'(ay)) : $signed(EW'(ax));
    ld_err = (ld_mnr <<< 1) - ld_maj;
    if (!OCT_GT[ld_oct]) begin
      ld_err = -ld_err;
    end
  end

  // Step: end test, error update and pixel moves.
  logic                 st_xm, st_done, st_minor;
  logic signed [EW-1:0] st_maj2, st_mnr2, st_err;
  logic [CW-1:0]        step_x, step_y;

  always_comb begin
    st_xm    = OCT_XMAJOR[octant_q];
    st_done  = st_xm ? (cur_x_q == stop_x_q) : (cur_y_q == stop_y_q);
    st_maj2  = $signed(EW'(st_xm ? mag_dx_q : mag_dy_q)) <<< 1;
    st_mnr2  = $signed(EW'(st_xm ? mag_dy_q : mag_dx_q)) <<< 1;
    if (OCT_GT[octant_q]) begin
      st_minor = error_q > 0;
      st_err   = error_q - (st_minor ? st_maj2 : '0) + st_mnr2;
    end else begin
      st_minor = error_q < 0;
      st_err   = error_q + (st_minor ? st_maj2 : '0) - st_mnr2;
    end
    step_x = OCT_XINC[octant_q] ? cur_x_q + CW'(1) : cur_x_q - CW'(1);
    step_y = OCT_YINC[octant_q] ? cur_y_q + CW'(1) : cur_y_q - CW'(1);
  end

  // Next line state and the result of the item at the input.
  logic res_on;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    stop_x_d = stop_x_q;
    stop_y_d = stop_y_q;
    mag_dx_d = mag_dx_q;
    mag_dy_d = mag_dy_q;
    error_d  = error_q;
    octant_d = octant_q;
    active_d = active_q;
    res_on   = 1'b0;
    case (action_e'(action_i))
      ACT_LOAD: begin
        cur_x_d  = start_x_i;
        cur_y_d  = start_y_i;
        stop_x_d = end_x_i;
        stop_y_d = end_y_i;
        mag_dx_d = ax;
        mag_dy_d = ay;
        if (dx == 0 && dy == 0) begin
          // Zero-length line: nothing to draw.
          octant_d = octant_t'(0);
          error_d  = '0;
          active_d = 1'b0;
        end else begin
          octant_d = ld_oct;
          error_d  = ld_err;
          active_d = 1'b1;
          res_on   = 1'b1;
        end
      end
      ACT_STEP: begin
        if (active_q) begin
          if (st_done) begin
            active_d = 1'b0;
          end else begin
            error_d = st_err;
            res_on  = 1'b1;
            if (st_xm) begin
              cur_x_d = step_x;
              if (st_minor) cur_y_d = step_y;
            end else begin
              cur_y_d = step_y;
              if (st_minor) cur_x_d = step_x;
            end
          end
        end
      end
      default: ;
    endcase
    res_d.pos_x   = cur_x_d;
    res_d.pos_y   = cur_y_d;
    res_d.on_line = res_on;
    res_d.octant  = octant_d;
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      stop_x_q <= '0;
      stop_y_q <= '0;
      mag_dx_q <= '0;
      mag_dy_q <= '0;
      error_q  <= '0;
      octant_q <= '0;
      active_q <= 1'b0;
    end else if (in_fire) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      stop_x_q <= stop_x_d;
      stop_y_q <= stop_y_d;
      mag_dx_q <= mag_dx_d;
      mag_dy_q <= mag_dy_d;
      error_q  <= error_d;
      octant_q <= octant_d;
      active_q <= active_d;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_q && !out_ready_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_q.pos_x;
  assign pos_y_o     = out_q.pos_y;
  assign on_line_o   = out_q.on_line;
  assign octant_o    = out_q.octant;

  // The skid entry only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // With the skid empty, the shown result is the newest one.
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !skid_valid_q) |->
      (out_q.pos_x == cur_x_q && out_q.pos_y == cur_y_q && out_q.octant == octant_q))
    else $error("latest result does not match line state");

  // A step with no active line leaves the point in place.
  a_idle_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == ACT_STEP && !active_q) |=>
      ($stable(cur_x_q) && $stable(cur_y_q) && !active_q))
    else $error("idle step moved the point");

  // A zero-length load leaves no active line.
  a_zero_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == ACT_LOAD && start_x_i == end_x_i && start_y_i == end_y_i)
      |=> (!active_q && octant_q == octant_t'(0)))
    else $error("zero-length load left a line active");

endmodule : bresenham_line_stepper_core

// ===== sim/bresenham_line_stepper_checker.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper_checker
// Watches both channels of the line stepper. Each accepted input item is run
// through a cycle-free model of the rasterizer to get the expected point, and
// each accepted result item is compared with the oldest expected point.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_checker
  import bls_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  action_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic                  on_line_i,
  input  logic [2:0]            octant_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t  pos_x;
    coord_t  pos_y;
    logic    on_line;
    octant_t octant;
  } line_point_t;

  // Shadow copy of the line state.
  coord_t                       cur_x, cur_y, stop_x, stop_y, mag_dx, mag_dy;
  logic signed [COORD_BITS+2:0] err_acc;
  octant_t                      line_oct;
  logic                         line_active;

  // Points still owed by the block, oldest first.
  line_point_t expected_points[$];

  // Octant from the signed deltas, counterclockwise from the positive x axis.
  function automatic octant_t classify_octant(int dx, int dy, int ax, int ay);
    if (dx > 0 && dy >= 0) return (ax > ay) ? 3'd0 : 3'd1;
    if (dx <= 0 && dy > 0) return (ax < ay) ? 3'd2 : 3'd3;
    if (dx < 0 && dy <= 0) return (ax >= ay) ? 3'd4 : 3'd5;
    return (ax < ay) ? 3'd6 : 3'd7;
  endfunction

  // Apply one item to the shadow state and return the point it reports.
  task automatic rasterize_item(input logic act, input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey,
                                output line_point_t res);
    int      dx, dy, ax, ay, major, minor, e, maj2, mnr2;
    logic    xmaj, done, minor_move;
    octant_t o;
    res.on_line = 1'b0;
    if (act == ACT_LOAD) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      cur_x  = sx;
      cur_y  = sy;
      stop_x = ex;
      stop_y = ey;
      mag_dx = coord_t'(ax);
      mag_dy = coord_t'(ay);
      if (dx == 0 && dy == 0) begin
        // A zero-length line reports its start and leaves nothing active.
        line_oct    = '0;
        err_acc     = '0;
        line_active = 1'b0;
      end else begin
        o     = classify_octant(dx, dy, ax, ay);
        major = OCT_XMAJOR[o] ? ax : ay;
        minor = OCT_XMAJOR[o] ? ay : ax;
        e     = 2 * minor - major;
        line_oct    = o;
        err_acc     = (COORD_BITS+3)'(OCT_GT[o] ? e : -e);
        line_active = 1'b1;
        res.on_line = 1'b1;
      end
    end else if (line_active) begin
      o    = line_oct;
      xmaj = OCT_XMAJOR[o];
      done = xmaj ? (cur_x == stop_x) : (cur_y == stop_y);
      if (done) begin
        // Major coordinate already at the end: hold position and finish.
        line_active = 1'b0;
      end else begin
        maj2 = 2 * int'(xmaj ? mag_dx : mag_dy);
        mnr2 = 2 * int'(xmaj ? mag_dy : mag_dx);
        e    = int'(err_acc);
        if (OCT_GT[o]) begin
          minor_move = (e > 0);
          if (minor_move) e = e - maj2;
          e = e + mnr2;
        end else begin
          minor_move = (e < 0);
          if (minor_move) e = e + maj2;
          e = e - mnr2;
        end
        err_acc = (COORD_BITS+3)'(e);
        if (xmaj) begin
          cur_x = OCT_XINC[o] ? cur_x + 1'b1 : cur_x - 1'b1;
          if (minor_move) cur_y = OCT_YINC[o] ? cur_y + 1'b1 : cur_y - 1'b1;
        end else begin
          cur_y = OCT_YINC[o] ? cur_y + 1'b1 : cur_y - 1'b1;
          if (minor_move) cur_x = OCT_XINC[o] ? cur_x + 1'b1 : cur_x - 1'b1;
        end
        res.on_line = 1'b1;
      end
    end
    res.pos_x  = cur_x;
    res.pos_y  = cur_y;
    res.octant = line_oct;
  endtask

  // Compare results first, then queue the prediction for a new input item.
  always @(posedge clk_i or negedge rst_ni) begin
    line_point_t want, got, fresh;
    if (!rst_ni) begin
      cur_x        = '0;
      cur_y        = '0;
      stop_x       = '0;
      stop_y       = '0;
      mag_dx       = '0;
      mag_dy       = '0;
      err_acc      = '0;
      line_oct     = '0;
      line_active  = 1'b0;
      expected_points.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {pos_x_i, pos_y_i, on_line_i, octant_i};
        if (expected_points.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] unexpected result item: pos=(%0d,%0d) on_line=%0b octant=%0d",
                     $time, got.pos_x, got.pos_y, got.on_line, got.octant);
        end else begin
          want = expected_points.pop_front();
          if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
              got.on_line !== want.on_line || got.octant !== want.octant) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("[%0t] result mismatch: expected pos=(%0d,%0d) on_line=%0b octant=%0d,",
                       $time, want.pos_x, want.pos_y, want.on_line, want.octant,
                       " got pos=(%0d,%0d) on_line=%0b octant=%0d",
                       got.pos_x, got.pos_y, got.on_line, got.octant);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        rasterize_item(action_i, start_x_i, start_y_i, end_x_i, end_y_i, fresh);
        expected_points.push_back(fresh);
      end
      pending_o = expected_points.size();
    end
  end

endmodule : bresenham_line_stepper_checker

// ===== sim/tb_bresenham_line_stepper_core.sv =====
// ----------------------------------------------------------------------------
// tb_bresenham_line_stepper_core
// Drives the line stepper with a directed pass over every octant and the end
// cases, then with random lines (short ones stepped to and past their ends),
// mixed with stray items, under random gaps on both channels. The checker
// does the comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_bresenham_line_stepper_core;
  import bls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS  = 12;
  localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          CYCLE_LIMIT = 500000;

  typedef logic [COORD_BITS-1:0] coord_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  logic   action_i    = ACT_LOAD;
  coord_t start_x_i   = '0;
  coord_t start_y_i   = '0;
  coord_t end_x_i     = '0;
  coord_t end_y_i     = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  coord_t pos_x_o, pos_y_o;
  logic   on_line_o;
  logic [2:0] octant_o;

  int fail_count;
  int pending_points;
  int items_sent = 0;
  int cycle_cnt  = 0;
  int stall_left = 0;
  bit burst_mode = 1'b0;

  bresenham_line_stepper_core #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .on_line_o  (on_line_o),
    .octant_o   (octant_o)
  );

  bresenham_line_stepper_checker #(
    .COORD_BITS(COORD_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .action_i    (action_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .pos_x_i     (pos_x_o),
    .pos_y_i     (pos_y_o),
    .on_line_i   (on_line_o),
    .octant_i    (octant_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_points)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run-away guard.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bresenham_line_stepper_core: mismatch");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 24);
  endfunction

  // Result side back-pressure; no new stall starts during bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!burst_mode && $urandom_range(0, 99) < 25) stall_left = idle_len();
    end
  end

  // Present one item after an optional gap and hold it until accepted.
  task automatic send_item(input action_e act, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    int gap;
    gap = (!burst_mode && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      action_i   <= 1'($urandom_range(0, 1));
      start_x_i  <= coord_t'($urandom_range(0, COORD_MAX));
      end_y_i    <= coord_t'($urandom_range(0, COORD_MAX));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Load a line and follow it with a number of steps carrying junk coordinates.
  task automatic trace_line(input int sx, input int sy, input int ex, input int ey,
                            input int n_steps);
    send_item(ACT_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
    repeat (n_steps)
      send_item(ACT_STEP, coord_t'($urandom_range(0, COORD_MAX)),
                coord_t'($urandom_range(0, COORD_MAX)),
                coord_t'($urandom_range(0, COORD_MAX)),
                coord_t'($urandom_range(0, COORD_MAX)));
  endtask

  // Random line: mostly short, some medium, a few with arbitrary endpoints.
  task automatic draw_random_line();
    int sx, sy, ex, ey, dx, dy, span, major, r, adx, ady;
    r  = $urandom_range(0, 99);
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    if (r < 5) begin
      ex = $urandom_range(0, COORD_MAX);
      ey = $urandom_range(0, COORD_MAX);
    end else begin
      span = (r < 20) ? 200 : 12;
      dx = int'($urandom_range(0, 2 * span)) - span;
      dy = int'($urandom_range(0, 2 * span)) - span;
      // Diagonals sit on the octant boundaries.
      if ($urandom_range(0, 9) == 0) dy = $urandom_range(0, 1) ? dx : -dx;
      ex = sx + dx;
      if (ex < 0 || ex > COORD_MAX) ex = sx - dx;
      ey = sy + dy;
      if (ey < 0 || ey > COORD_MAX) ey = sy - dy;
    end
    adx   = (ex > sx) ? ex - sx : sx - ex;
    ady   = (ey > sy) ? ey - sy : sy - ey;
    major = (adx > ady) ? adx : ady;
    trace_line(sx, sy, ex, ey,
               (major <= 40) ? major + $urandom_range(0, 3) : $urandom_range(1, 60));
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Step with no line loaded, then a zero-length line at the far corner.
    send_item(ACT_STEP, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX));
    trace_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
    // One short line per octant, stepped to its end and once more.
    trace_line(COORD_MAX - 1, 0, COORD_MAX, 0, 2);
    trace_line(0, 0, 1, 1, 2);
    trace_line(COORD_MAX, COORD_MAX - 1, COORD_MAX, COORD_MAX, 2);
    trace_line(1, 0, 0, 1, 2);
    trace_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX, 2);
    trace_line(1, 2, 0, 0, 3);
    trace_line(0, COORD_MAX, 0, COORD_MAX - 1, 2);
    trace_line(COORD_MAX - 1, 1, COORD_MAX, 0, 2);

    // Random lines with a sprinkling of stray items.
    while (items_sent < RANDOM_ITEMS + 30) begin
      if ($urandom_range(0, 11) == 0) burst_mode = ~burst_mode;
      if ($urandom_range(0, 99) < 88) begin
        draw_random_line();
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(action_e'($urandom_range(0, 1)),
                    coord_t'($urandom_range(0, COORD_MAX)),
                    coord_t'($urandom_range(0, COORD_MAX)),
                    coord_t'($urandom_range(0, COORD_MAX)),
                    coord_t'($urandom_range(0, COORD_MAX)));
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then keep watching for stray results before the verdict.
    while (pending_points != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0)
      $display("bresenham_line_stepper_core: match");
    else
      $display("bresenham_line_stepper_core: mismatch");
    $finish;
  end

endmodule : tb_bresenham_line_stepper_core
